/* rtl/lik_pkg.sv */
package lik_pkg;

  // Field and register widths
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned IDX_W   = 2;

  // Datapath widths
  localparam int unsigned DSQ_W    = 32;  // squared length, Q32
  localparam int unsigned DEN_W    = 33;  // 2*a*b, Q32
  localparam int unsigned NUM_W    = 35;  // signed law-of-cosines numerator
  localparam int unsigned REM_W    = DEN_W + 1;
  localparam int unsigned COS_FRAC = 14;  // cosine fraction bits
  localparam int unsigned CORD_W   = 26;  // CORDIC x/y
  localparam int unsigned Z_W      = 20;  // CORDIC angle, Q16

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_STAGES_MAX = 24;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_THIGH = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SHANK = 2'd1;
  localparam logic [IDX_W-1:0] CFG_WHEEL = 2'd2;

  localparam logic [LEN_W-1:0] THIGH_RST = 16'd19661;
  localparam logic [LEN_W-1:0] SHANK_RST = 16'd22495;
  localparam logic [LEN_W-1:0] WHEEL_RST = 16'd4915;

  localparam logic signed [Z_W-1:0] HALFPI_Q16 = 20'sd102944;

  localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_STAGES_MAX] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

endpackage

/* rtl/lik_sqrt.sv */
module lik_sqrt #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned W      = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [W-1:0]          rad_i  [LANES],
  input  logic [SIDE_W-1:0]     side_i,
  output logic [W/2-1:0]        root_o [LANES],
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned STEPS = W / 2;

  logic [W-1:0]      v_q    [STEPS][LANES];
  logic [W-1:0]      res_q  [STEPS][LANES];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [W-1:0] v_in, res_in, v_d, res_d;
      logic [W:0]   trial;

      if (k == 0) begin : g_first
        assign v_in   = rad_i[l];
        assign res_in = '0;
      end else begin : g_next
        assign v_in   = v_q[k-1][l];
        assign res_in = res_q[k-1][l];
      end

      // One root bit: subtract the trial value where it fits
      always_comb begin
        trial = {1'b0, res_in} + {1'b0, BIT};
        if ({1'b0, v_in} >= trial) begin
          v_d   = v_in - trial[W-1:0];
          res_d = (res_in >> 1) + BIT;
        end else begin
          v_d   = v_in;
          res_d = res_in >> 1;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[k][l]   <= v_d;
          res_q[k][l] <= res_d;
        end
      end
    end

    if (k == 0) begin : g_side_first
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_i;
      end
    end else begin : g_side_next
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign root_o[l] = res_q[STEPS-1][l][STEPS-1:0];
  end
  assign side_o = side_q[STEPS-1];

endmodule

/* rtl/lik_div.sv */
module lik_div #(
  parameter int unsigned LANES  = 2,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [lik_pkg::REM_W-1:0]        mag_i [LANES],
  input  logic [lik_pkg::DEN_W-1:0]        den_i [LANES],
  input  logic [SIDE_W-1:0]                side_i,
  output logic [lik_pkg::COS_FRAC-1:0]     quo_o [LANES],
  output logic [SIDE_W-1:0]                side_o
);

  localparam int unsigned STEPS = lik_pkg::COS_FRAC;
  localparam int unsigned RW    = lik_pkg::REM_W;
  localparam int unsigned DW    = lik_pkg::DEN_W;

  logic [RW-1:0]     r_q    [STEPS][LANES];
  logic [DW-1:0]     den_q  [STEPS][LANES];
  logic [STEPS-1:0]  q_q    [STEPS][LANES];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0]    r_in, r_sh, r_d;
      logic [DW-1:0]    den_in;
      logic [STEPS-1:0] q_in, q_d;

      if (k == 0) begin : g_first
        assign r_in   = mag_i[l];
        assign den_in = den_i[l];
        assign q_in   = '0;
      end else begin : g_next
        assign r_in   = r_q[k-1][l];
        assign den_in = den_q[k-1][l];
        assign q_in   = q_q[k-1][l];
      end

      // Restoring step: shift in a zero, subtract the divisor where it fits
      always_comb begin
        r_sh = {r_in[RW-2:0], 1'b0};
        if (r_sh >= {1'b0, den_in}) begin
          r_d = r_sh - {1'b0, den_in};
          q_d = {q_in[STEPS-2:0], 1'b1};
        end else begin
          r_d = r_sh;
          q_d = {q_in[STEPS-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k][l]   <= r_d;
          den_q[k][l] <= den_in;
          q_q[k][l]   <= q_d;
        end
      end
    end

    if (k == 0) begin : g_side_first
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_i;
      end
    end else begin : g_side_next
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = q_q[STEPS-1][l];
  end
  assign side_o = side_q[STEPS-1];

endmodule

/* rtl/lik_cordic.sv */
module lik_cordic #(
  parameter int unsigned STAGES = lik_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned LANES  = 3,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lik_pkg::CORD_W-1:0]   y_i [LANES],
  input  logic signed [lik_pkg::CORD_W-1:0]   x_i [LANES],
  input  logic [SIDE_W-1:0]                   side_i,
  output logic signed [lik_pkg::Z_W-1:0]      z_o [LANES],
  output logic [SIDE_W-1:0]                   side_o
);

  localparam int unsigned CW = lik_pkg::CORD_W;
  localparam int unsigned ZW = lik_pkg::Z_W;

  logic signed [CW-1:0] x_q    [STAGES][LANES];
  logic signed [CW-1:0] y_q    [STAGES][LANES];
  logic signed [ZW-1:0] z_q    [STAGES][LANES];
  logic [SIDE_W-1:0]    side_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [CW-1:0] x_in, y_in, x_d, y_d;
      logic signed [ZW-1:0] z_in, z_d;

      if (k == 0) begin : g_first
        // Turn a left-half vector by a quarter turn toward +x
        always_comb begin
          if (x_i[l] < 0) begin
            if (y_i[l] >= 0) begin
              x_in = y_i[l];
              y_in = -x_i[l];
              z_in = lik_pkg::HALFPI_Q16;
            end else begin
              x_in = -y_i[l];
              y_in = x_i[l];
              z_in = -lik_pkg::HALFPI_Q16;
            end
          end else begin
            x_in = x_i[l];
            y_in = y_i[l];
            z_in = '0;
          end
        end
      end else begin : g_next
        assign x_in = x_q[k-1][l];
        assign y_in = y_q[k-1][l];
        assign z_in = z_q[k-1][l];
      end

      // Rotate toward the x axis and accumulate the turned angle
      always_comb begin
        if (y_in >= 0) begin
          x_d = x_in + (y_in >>> k);
          y_d = y_in - (x_in >>> k);
          z_d = z_in + lik_pkg::ATAN_Q16[k];
        end else begin
          x_d = x_in - (y_in >>> k);
          y_d = y_in + (x_in >>> k);
          z_d = z_in - lik_pkg::ATAN_Q16[k];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k][l] <= x_d;
          y_q[k][l] <= y_d;
          z_q[k][l] <= z_d;
        end
      end
    end

    if (k == 0) begin : g_side_first
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_i;
      end
    end else begin : g_side_next
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign z_o[l] = z_q[STAGES-1][l];
  end
  assign side_o = side_q[STAGES-1];

endmodule

/* rtl/leg_inverse_kinematics.sv */
// Two-link wheeled-leg inverse kinematics. Each input transaction carries a
// target body height (Q16 m) and a body pitch (Q12 rad); each yields exactly
// one output transaction with the hip angle, the knee angle and the absolute
// shank angle (Q12 rad, saturated to 16 bits). The datapath is a fully
// pipelined chain of cells and accepts one transaction per clock while the
// output is not stalled; the chain runs through the 16-cell square root of
// the leg span, the 14-cell cosine dividers, the 15-cell square roots for
// the sines and the CORDIC angle cells. A stall at the output freezes the
// whole chain. Thigh length, shank length and wheel radius are written through
// the configuration port (always ready) and must only change while the block
// is empty.
module leg_inverse_kinematics #(
  parameter int unsigned CORDIC_STAGES = lik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lik_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [lik_pkg::LEN_W-1:0]           cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lik_pkg::LEN_W-1:0]           target_height_i,
  input  logic signed [lik_pkg::PITCH_W-1:0]  body_pitch_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lik_pkg::ANG_W-1:0]    hip_angle_o,
  output logic signed [lik_pkg::ANG_W-1:0]    knee_angle_o,
  output logic signed [lik_pkg::ANG_W-1:0]    shank_angle_o
);

  localparam int unsigned LW   = lik_pkg::LEN_W;
  localparam int unsigned PW   = lik_pkg::PITCH_W;
  localparam int unsigned DSW  = lik_pkg::DSQ_W;
  localparam int unsigned DNW  = lik_pkg::DEN_W;
  localparam int unsigned NW   = lik_pkg::NUM_W;
  localparam int unsigned RW   = lik_pkg::REM_W;
  localparam int unsigned CF   = lik_pkg::COS_FRAC;
  localparam int unsigned CW   = lik_pkg::CORD_W;
  localparam int unsigned ZW   = lik_pkg::Z_W;
  localparam int unsigned SQ2W = 2 * (CF + 1);  // radicand width for the sines
  localparam int unsigned LAT  = 51 + CORDIC_STAGES;

  localparam int unsigned SQ1_SIDE_W = 3 * DSW + DNW + LW + PW + LW;
  localparam int unsigned DIV_SIDE_W = 4 + PW + LW;
  localparam int unsigned SQ2_SIDE_W = 2 * (CF + 2) + PW + LW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LW-1:0] thigh_q, shank_q, wheel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thigh_q <= lik_pkg::THIGH_RST;
      shank_q <= lik_pkg::SHANK_RST;
      wheel_q <= lik_pkg::WHEEL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lik_pkg::CFG_THIGH: thigh_q <= cfg_data_i;
        lik_pkg::CFG_SHANK: shank_q <= cfg_data_i;
        lik_pkg::CFG_WHEEL: wheel_q <= cfg_data_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: one valid bit per pipeline stage, one global advance
  // ---------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: hip-to-wheel drop, clamped to 0.10 .. 0.60 m
  // ---------------------------------------------------------------------------
  logic signed [LW+1:0] drop_raw;
  logic [LW-1:0]        drop_clamped;
  logic [LW-1:0]        s1_drop_q, s1_t_q, s1_s_q;
  logic signed [PW-1:0] s1_pitch_q;

  always_comb begin
    drop_raw = $signed({2'b00, target_height_i}) - 18'sd4588 - $signed({2'b00, wheel_q});
    if (drop_raw < 18'sd6554) begin
      drop_clamped = 16'd6554;
    end else if (drop_raw > 18'sd39322) begin
      drop_clamped = 16'd39322;
    end else begin
      drop_clamped = drop_raw[LW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_drop_q  <= drop_clamped;
      s1_t_q     <= thigh_q;
      s1_s_q     <= shank_q;
      s1_pitch_q <= body_pitch_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the span and the links
  // ---------------------------------------------------------------------------
  logic [DSW-1:0]       s2_dsq_q, s2_tt_q, s2_ss_q;
  logic [DNW-1:0]       s2_ts2_q;
  logic [LW-1:0]        s2_t_q, s2_drop_q;
  logic signed [PW-1:0] s2_pitch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // lateral offset of 745 LSB enters squared
      s2_dsq_q   <= 32'd555025 + s1_drop_q * s1_drop_q;
      s2_tt_q    <= s1_t_q * s1_t_q;
      s2_ss_q    <= s1_s_q * s1_s_q;
      s2_ts2_q   <= {DSW'(s1_t_q) * DSW'(s1_s_q), 1'b0};
      s2_t_q     <= s1_t_q;
      s2_drop_q  <= s1_drop_q;
      s2_pitch_q <= s1_pitch_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Span d = floor(sqrt(d_sq))
  // ---------------------------------------------------------------------------
  logic [DSW-1:0]        sq1_rad  [1];
  logic [DSW/2-1:0]      sq1_root [1];
  logic [SQ1_SIDE_W-1:0] sq1_side_in, sq1_side_out;

  logic [DSW-1:0]       a_tt, a_ss, a_dsq;
  logic [DNW-1:0]       a_ts2;
  logic [LW-1:0]        a_t, a_drop;
  logic signed [PW-1:0] a_pitch;

  assign sq1_rad[0]  = s2_dsq_q;
  assign sq1_side_in = {s2_tt_q, s2_ss_q, s2_ts2_q, s2_dsq_q, s2_t_q, s2_pitch_q, s2_drop_q};
  assign {a_tt, a_ss, a_ts2, a_dsq, a_t, a_pitch, a_drop} = sq1_side_out;

  lik_sqrt #(
    .LANES  (1),
    .W      (DSW),
    .SIDE_W (SQ1_SIDE_W)
  ) u_sqrt_span (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq1_rad),
    .side_i (sq1_side_in),
    .root_o (sq1_root),
    .side_o (sq1_side_out)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: law-of-cosines numerators and denominators
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] s3_numg_q, s3_nump_q;
  logic [DNW-1:0]       s3_deng_q, s3_denp_q;
  logic [LW-1:0]        s3_drop_q;
  logic signed [PW-1:0] s3_pitch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_numg_q  <= $signed({3'b000, a_tt}) + $signed({3'b000, a_ss})
                    - $signed({3'b000, a_dsq});
      s3_nump_q  <= $signed({3'b000, a_tt}) + $signed({3'b000, a_dsq})
                    - $signed({3'b000, a_ss});
      s3_deng_q  <= a_ts2;
      s3_denp_q  <= {DSW'(a_t) * DSW'(sq1_root[0]), 1'b0};
      s3_drop_q  <= a_drop;
      s3_pitch_q <= a_pitch;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: magnitudes and the clamp to +-1 (also covers a zero denominator)
  // ---------------------------------------------------------------------------
  logic [NW-1:0]        absg, absp;
  logic [RW-1:0]        s4_magg_q, s4_magp_q;
  logic [DNW-1:0]       s4_deng_q, s4_denp_q;
  logic                 s4_satg_q, s4_negg_q, s4_satp_q, s4_negp_q;
  logic [LW-1:0]        s4_drop_q;
  logic signed [PW-1:0] s4_pitch_q;

  assign absg = s3_numg_q[NW-1] ? NW'(-s3_numg_q) : NW'(s3_numg_q);
  assign absp = s3_nump_q[NW-1] ? NW'(-s3_nump_q) : NW'(s3_nump_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_magg_q  <= absg[RW-1:0];
      s4_magp_q  <= absp[RW-1:0];
      s4_deng_q  <= s3_deng_q;
      s4_denp_q  <= s3_denp_q;
      s4_satg_q  <= (s3_deng_q == '0) || (absg[RW-1:0] >= {1'b0, s3_deng_q});
      s4_satp_q  <= (s3_denp_q == '0) || (absp[RW-1:0] >= {1'b0, s3_denp_q});
      s4_negg_q  <= s3_numg_q[NW-1];
      s4_negp_q  <= s3_nump_q[NW-1];
      s4_drop_q  <= s3_drop_q;
      s4_pitch_q <= s3_pitch_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Cosine magnitudes, Q14, lane 0 gamma and lane 1 psi
  // ---------------------------------------------------------------------------
  logic [RW-1:0]         div_mag [2];
  logic [DNW-1:0]        div_den [2];
  logic [CF-1:0]         div_quo [2];
  logic [DIV_SIDE_W-1:0] div_side_in, div_side_out;

  logic                 b_satg, b_negg, b_satp, b_negp;
  logic [LW-1:0]        b_drop;
  logic signed [PW-1:0] b_pitch;

  assign div_mag[0]  = s4_magg_q;
  assign div_mag[1]  = s4_magp_q;
  assign div_den[0]  = s4_deng_q;
  assign div_den[1]  = s4_denp_q;
  assign div_side_in = {s4_satg_q, s4_negg_q, s4_satp_q, s4_negp_q, s4_pitch_q, s4_drop_q};
  assign {b_satg, b_negg, b_satp, b_negp, b_pitch, b_drop} = div_side_out;

  lik_div #(
    .LANES  (2),
    .SIDE_W (DIV_SIDE_W)
  ) u_div_cos (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (div_mag),
    .den_i  (div_den),
    .side_i (div_side_in),
    .quo_o  (div_quo),
    .side_o (div_side_out)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: signed cosines and 1 - c^2 for the sines
  // ---------------------------------------------------------------------------
  logic [CF:0]          cmagg, cmagp;
  logic signed [CF+1:0] s5_cg_q, s5_cp_q;
  logic [SQ2W-1:0]      s5_radg_q, s5_radp_q;
  logic [LW-1:0]        s5_drop_q;
  logic signed [PW-1:0] s5_pitch_q;

  assign cmagg = b_satg ? (CF+1)'(1 << CF) : {1'b0, div_quo[0]};
  assign cmagp = b_satp ? (CF+1)'(1 << CF) : {1'b0, div_quo[1]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_cg_q    <= b_negg ? -$signed({1'b0, cmagg}) : $signed({1'b0, cmagg});
      s5_cp_q    <= b_negp ? -$signed({1'b0, cmagp}) : $signed({1'b0, cmagp});
      s5_radg_q  <= SQ2W'(1 << (2 * CF)) - SQ2W'(cmagg) * SQ2W'(cmagg);
      s5_radp_q  <= SQ2W'(1 << (2 * CF)) - SQ2W'(cmagp) * SQ2W'(cmagp);
      s5_drop_q  <= b_drop;
      s5_pitch_q <= b_pitch;
    end
  end

  // ---------------------------------------------------------------------------
  // Sines, Q14
  // ---------------------------------------------------------------------------
  logic [SQ2W-1:0]       sq2_rad  [2];
  logic [SQ2W/2-1:0]     sq2_root [2];
  logic [SQ2_SIDE_W-1:0] sq2_side_in, sq2_side_out;

  logic signed [CF+1:0] c_cg, c_cp;
  logic [LW-1:0]        c_drop;
  logic signed [PW-1:0] c_pitch;

  assign sq2_rad[0]  = s5_radg_q;
  assign sq2_rad[1]  = s5_radp_q;
  assign sq2_side_in = {s5_cg_q, s5_cp_q, s5_pitch_q, s5_drop_q};
  assign {c_cg, c_cp, c_pitch, c_drop} = sq2_side_out;

  lik_sqrt #(
    .LANES  (2),
    .W      (SQ2W),
    .SIDE_W (SQ2_SIDE_W)
  ) u_sqrt_sin (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq2_rad),
    .side_i (sq2_side_in),
    .root_o (sq2_root),
    .side_o (sq2_side_out)
  );

  // ---------------------------------------------------------------------------
  // Angles by CORDIC: lane 0 gamma, lane 1 psi, lane 2 theta_d.
  // All vectors enter scaled by 256.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] cor_y [3];
  logic signed [CW-1:0] cor_x [3];
  logic signed [ZW-1:0] cor_z [3];
  logic [PW-1:0]        cor_side_out;
  logic signed [PW-1:0] d_pitch;

  assign cor_y[0] = $signed({{(CW-CF-9){1'b0}}, sq2_root[0], 8'b0});
  assign cor_x[0] = $signed({{(CW-CF-10){c_cg[CF+1]}}, c_cg, 8'b0});
  assign cor_y[1] = $signed({{(CW-CF-9){1'b0}}, sq2_root[1], 8'b0});
  assign cor_x[1] = $signed({{(CW-CF-10){c_cp[CF+1]}}, c_cp, 8'b0});
  assign cor_y[2] = -26'sd190720;  // lateral offset of -745 LSB
  assign cor_x[2] = $signed({{(CW-LW-8){1'b0}}, c_drop, 8'b0});
  assign d_pitch  = $signed(cor_side_out);

  lik_cordic #(
    .STAGES (CORDIC_STAGES),
    .LANES  (3),
    .SIDE_W (PW)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (cor_y),
    .x_i    (cor_x),
    .side_i (c_pitch),
    .z_o    (cor_z),
    .side_o (cor_side_out)
  );

  // ---------------------------------------------------------------------------
  // Output stage: round Q16 to Q12, combine, saturate
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] sat16(input logic signed [ZW-1:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic signed [ZW-1:0] gam, psi, th, phi1, pig, hip, knee, shank;

  always_comb begin
    gam   = (cor_z[0] + 20'sd8) >>> 4;
    psi   = (cor_z[1] + 20'sd8) >>> 4;
    th    = (cor_z[2] + 20'sd8) >>> 4;
    phi1  = th - psi;
    pig   = 20'sd12868 - gam;
    hip   = phi1 + 20'sd5579 + $signed({{(ZW-PW){d_pitch[PW-1]}}, d_pitch});
    knee  = pig - 20'sd9530;
    shank = phi1 + pig;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hip_angle_o   <= sat16(hip);
      knee_angle_o  <= sat16(knee);
      shank_angle_o <= sat16(shank);
    end
  end

`ifndef SYNTHESIS
  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // An accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transaction lost at entry");

  // The result slot is filled from the last chain stage on every advance
  a_out_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (out_valid_o == $past(vld_q[LAT-2])))
    else $error("result slot out of step with the chain");

  // A thigh write lands in its register
  a_cfg_thigh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == lik_pkg::CFG_THIGH)
    |=> (thigh_q == $past(cfg_data_i)))
    else $error("thigh length write not taken");
`endif

endmodule
